// File: hdl/pge_pkg.sv
// Package with the shared constants and types of the permutation graph edge block.
package pge_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int STORE_BITS   = 32;
  localparam int VAL_W        = 5;

  // Vertices above the store width cannot be held, so the usable range is clipped.
  localparam int VERT_LIMIT = (MAX_VERTICES > STORE_BITS) ? STORE_BITS : MAX_VERTICES;

  localparam logic [STORE_BITS-1:0] LIMIT_MASK =
    (VERT_LIMIT >= STORE_BITS) ? {STORE_BITS{1'b1}}
                               : ((STORE_BITS'(1) << VERT_LIMIT) - STORE_BITS'(1));

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  // One classified request waiting for the back end.
  typedef struct packed {
    logic             start_req;
    logic             in_range;
    logic [VAL_W-1:0] value;
  } req_t;

endpackage

// File: hdl/permutation_graph_edges.sv
// Top level of the permutation graph edge generator.
// Values of a permutation arrive one per request; a request with tuser set starts a
// new permutation and clears the set of seen values first. For each value the block
// sends one edge per earlier, greater value, in ascending order of the earlier value,
// with tlast on the final edge of that run; a value with no greater predecessor, or
// one at or above the vertex limit, sends nothing. The back end's edge scanner sets
// the rate: it holds each value while its edges go out, stalling with the output,
// and takes the next value as the last edge moves out, and a two-entry request queue
// in front lets input requests be taken while the scanner or the output is busy.
module permutation_graph_edges (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pge_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [4:0] value, [7:5] zero
  input  logic                             s_axis_tuser,  // [0] start_req
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [pge_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [4:0] earlier_value,
                                                         // [9:5] later_value, [15:10] zero
  output logic                             m_axis_tlast   // last_of_run
);

  logic          req_valid;
  logic          req_pop;
  pge_pkg::req_t req;

  pge_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .req_valid_o   (req_valid),
    .req_pop_i     (req_pop),
    .req_o         (req)
  );

  pge_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_valid),
    .req_pop_o     (req_pop),
    .req_i         (req),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: hdl/pge_front.sv
// Front end: accepts input requests, classifies them and queues them for the back end.
module pge_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pge_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [4:0] value, [7:5] zero
  input  logic                             s_axis_tuser,  // [0] start_req
  output logic                             req_valid_o,
  input  logic                             req_pop_i,
  output pge_pkg::req_t                    req_o
);

  pge_pkg::req_t                   mem_q [pge_pkg::QUEUE_DEPTH];
  logic [pge_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [pge_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [pge_pkg::QCNT_W-1:0]      count_q, count_d;
  logic                            push, pop;
  pge_pkg::req_t                   new_req;

  assign s_axis_tready = (count_q != pge_pkg::QCNT_W'(pge_pkg::QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign req_valid_o   = (count_q != '0);
  assign pop           = req_pop_i && req_valid_o;
  assign req_o         = mem_q[rd_ptr_q];

  always_comb begin
    new_req.start_req = s_axis_tuser;
    new_req.value     = s_axis_tdata[pge_pkg::VAL_W-1:0];
    new_req.in_range  = ({1'b0, s_axis_tdata[pge_pkg::VAL_W-1:0]}
                         < (pge_pkg::VAL_W+1)'(pge_pkg::VERT_LIMIT));
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == pge_pkg::QPTR_W'(pge_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + pge_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == pge_pkg::QPTR_W'(pge_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + pge_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + pge_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - pge_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_req;
    end
  end

endmodule

// File: hdl/pge_back.sv
// Back end: keeps the set of seen values and emits one inversion edge per cycle while the output is ready.
module pge_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  output logic                             req_pop_o,
  input  pge_pkg::req_t                    req_i,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [pge_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [4:0] earlier_value,
                                                         // [9:5] later_value, [15:10] zero
  output logic                             m_axis_tlast   // last_of_run
);

  logic [pge_pkg::STORE_BITS-1:0] seen_q, seen_d;
  logic [pge_pkg::STORE_BITS-1:0] pend_q, pend_d;
  logic                           busy_q, busy_d;
  logic [pge_pkg::VAL_W-1:0]      later_q, later_d;
  logic                           ovalid_q, ovalid_d;
  logic [pge_pkg::VAL_W-1:0]      oearly_q, oearly_d;
  logic [pge_pkg::VAL_W-1:0]      olater_q, olater_d;
  logic                           olast_q, olast_d;

  logic [pge_pkg::STORE_BITS-1:0] low_bit, rest, base, above, one_hot_v;
  logic [pge_pkg::VAL_W-1:0]      low_idx;
  logic                           advance, take;

  // Lowest pending earlier value, encoded from its isolated one-hot bit.
  always_comb begin
    low_bit = pend_q & (~pend_q + pge_pkg::STORE_BITS'(1));
    rest    = pend_q & ~low_bit;
    low_idx = '0;
    for (int i = 0; i < pge_pkg::STORE_BITS; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | pge_pkg::VAL_W'(i);
      end
    end
  end

  // An edge moves into the output register when that register is free or drained.
  assign advance   = busy_q && (!ovalid_q || m_axis_tready);
  assign req_pop_o = !busy_q || (advance && (rest == '0));
  assign take      = req_pop_o && req_valid_i;

  always_comb begin
    base      = req_i.start_req ? '0 : seen_q;
    one_hot_v = pge_pkg::STORE_BITS'(1) << req_i.value;
    above     = ~((pge_pkg::STORE_BITS'(2) << req_i.value) - pge_pkg::STORE_BITS'(1))
                & pge_pkg::LIMIT_MASK;
  end

  always_comb begin
    seen_d   = seen_q;
    pend_d   = pend_q;
    busy_d   = busy_q;
    later_d  = later_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    oearly_d = oearly_q;
    olater_d = olater_q;
    olast_d  = olast_q;
    if (advance) begin
      ovalid_d = 1'b1;
      oearly_d = low_idx;
      olater_d = later_q;
      olast_d  = (rest == '0);
      pend_d   = rest;
      busy_d   = (rest != '0);
    end
    if (take) begin
      if (req_i.in_range) begin
        seen_d  = base | one_hot_v;
        pend_d  = base & above;
        busy_d  = ((base & above) != '0);
        later_d = req_i.value;
      end else begin
        seen_d = base;
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= '0;
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      seen_q   <= seen_d;
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q   <= pend_d;
    later_q  <= later_d;
    oearly_q <= oearly_d;
    olater_q <= olater_d;
    olast_q  <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {(pge_pkg::OUT_TDATA_W - 2*pge_pkg::VAL_W)'(0), olater_q, oearly_q};

endmodule
